// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TSED_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TSED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tsed_pkg.sv =====
package tsed_pkg;

	localparam int ALPHA_FRAC = 16;
	localparam int DIG_W      = 16;
	localparam int VAR_W      = 64;
	localparam int OPA_W      = 66;
	localparam int PROD_W     = OPA_W + DIG_W + 1;
	localparam int ACC_W      = 132;
	localparam int KK_W       = 24;
	localparam int KK_DIG     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMA      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_K        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERSIST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 3'd5;

	localparam logic [15:0] EMA_ALPHA_RST = 16'd655;
	localparam logic [15:0] VAR_ALPHA_RST = 16'd66;
	localparam logic [11:0] K_RST         = 12'd1024;
	localparam logic [7:0]  PERSIST_RST   = 8'd3;
	localparam logic [15:0] HOLDOFF_RST   = 16'd10;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} tsed_dir_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_E1M,
		ST_E1U,
		ST_E2M,
		ST_E2U,
		ST_E3M,
		ST_E3U,
		ST_BASE,
		ST_RES,
		ST_RSQ,
		ST_CLIP,
		ST_VARM,
		ST_VARU,
		ST_KK,
		ST_KKU,
		ST_THR,
		ST_DEC
	} tsed_state_t;

endpackage

// ===== hw/rtl/tema_step_event_detector.sv =====
// Step detector on a triple-EMA baseline with a clipped residual variance.
// Samples arrive on the sample channel (sample_valid, sample_stall); a
// request is taken when sample_valid is high and sample_stall is low.
// Confirmed steps leave on the event channel (event_valid, event_stall)
// from an output register that holds its request until it is taken.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the
// user must write them only while the block is idle, which the block
// does not enforce itself. Turning enable on clears the filter, baseline,
// variance, step-tracking, hold-off and sample-count state. Every enabled,
// seeded sample runs through one shared multiply-accumulate unit under a
// sequencer, and sample_stall stays high until it is back in idle; a
// disabled or seeding sample is handled in idle. An event appears on the
// cycle after the sequencer finishes. If the receiver stalls while an
// event waits and the decision step fires another, the sequencer holds
// its last step until the output register is free. Reset clears the
// state and loads the register defaults; the block starts disabled.
module tema_step_event_detector #(
	parameter int SAMPLE_BITS   = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          sample_valid,
	output logic                                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]                 sample,
	output logic                                          event_valid,
	input  logic                                          event_stall,
	output logic [31:0]                                   start_index,
	output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]   value_before,
	output logic signed [SAMPLE_BITS-1:0]                 value_after,
	output logic signed [SAMPLE_BITS+FRACTION_BITS+1:0]   step_size,
	output logic                                          step_down,
	input  logic                                          cfg_wr_en,
	input  logic [tsed_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [tsed_pkg::CFG_DATA_W-1:0]               cfg_data
);

`include "assert_macros.svh"

	localparam int EMA_W   = SAMPLE_BITS + FRACTION_BITS;
	localparam int BASE_W  = EMA_W + 2;
	localparam int SUM_W   = EMA_W + 3;
	localparam int R_W     = BASE_W + 1;
	localparam int RSQ_DIG = (R_W + tsed_pkg::DIG_W - 1) / tsed_pkg::DIG_W;
	localparam int LSH     = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
	localparam int RSH     = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int CMP_W   = tsed_pkg::ACC_W + 8;

	localparam logic signed [SUM_W-1:0] BASE_MAX = SUM_W'((64'sd1 <<< (BASE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] BASE_MIN = -SUM_W'(64'sd1 <<< (BASE_W - 1));
	localparam logic signed [BASE_W-1:0] EMA_MAX = BASE_W'((64'sd1 <<< (EMA_W - 1)) - 1);
	localparam logic signed [BASE_W-1:0] EMA_MIN = -BASE_W'(64'sd1 <<< (EMA_W - 1));

	tsed_pkg::tsed_state_t state_q, state_d;
	tsed_pkg::tsed_dir_t   sdir_q, dir;

	logic                          enable_q;
	logic [15:0]                   ema_alpha_q, var_alpha_q, holdoff_cfg_q, holdoff_q;
	logic [11:0]                   k_q;
	logic [7:0]                    persist_q, slen_q, slen_inc;
	logic                          seeded_q;
	logic signed [EMA_W-1:0]       e1_q, e2_q, e3_q;
	logic signed [BASE_W-1:0]      base_q, sbase_q;
	logic [tsed_pkg::VAR_W-1:0]    var_q, var_old_q;
	logic [31:0]                   count_q, sidx_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [R_W-1:0]         r_q;
	logic [tsed_pkg::KK_W-1:0]     kk_q;
	logic [tsed_pkg::ACC_W-1:0]    rsq_q;
	logic signed [tsed_pkg::OPA_W-1:0] opa_q;
	logic signed [tsed_pkg::ACC_W-1:0] acc_q, acc_d;
	logic [1:0]                    dig_q;

	logic                          ev_valid_q;
	logic [31:0]                   ev_index_q;
	logic signed [EMA_W-1:0]       ev_before_q;
	logic signed [SAMPLE_BITS-1:0] ev_after_q;
	logic signed [BASE_W-1:0]      ev_step_q;
	logic                          ev_down_q;

	logic                          accept, fire, gt, hold, ev_load;
	logic [tsed_pkg::DIG_W-1:0]    mdig;
	logic signed [tsed_pkg::PROD_W-1:0] prod;
	logic signed [tsed_pkg::ACC_W-1:0]  prod_sh;
	logic signed [EMA_W-1:0]       sq, sq_in, ema_step, e1n, e2n;
	logic signed [SUM_W-1:0]       base_sum;
	logic signed [BASE_W-1:0]      base_sat, before_sat;
	logic signed [R_W-1:0]         r_d;
	logic [R_W-1:0]                r_abs;
	logic [67:0]                   nine;
	logic [tsed_pkg::ACC_W-1:0]    cap, clip_sh;
	logic [tsed_pkg::VAR_W-1:0]    clipped;
	logic [CMP_W-1:0]              lhs_w, rhs_w;
	logic [63:0]                   rsq_src;
	logic [31:0]                   kk_src;

	assign accept   = sample_valid && !sample_stall;
	assign sq       = EMA_W'(sample_q) <<< FRACTION_BITS;
	assign sq_in    = EMA_W'(sample) <<< FRACTION_BITS;
	assign rsq_src  = opa_q[63:0];
	assign kk_src   = {8'd0, kk_q};

	always_comb begin
		unique case (state_q)
			tsed_pkg::ST_E1M, tsed_pkg::ST_E2M, tsed_pkg::ST_E3M: mdig = ema_alpha_q;
			tsed_pkg::ST_VARM: mdig = var_alpha_q;
			tsed_pkg::ST_KK:   mdig = {4'd0, k_q};
			tsed_pkg::ST_RSQ:  mdig = rsq_src[{dig_q, 4'd0} +: tsed_pkg::DIG_W];
			tsed_pkg::ST_THR:  mdig = kk_src[{dig_q[0], 4'd0} +: tsed_pkg::DIG_W];
			default:           mdig = '0;
		endcase
	end

	assign prod    = opa_q * $signed({1'b0, mdig});
	assign prod_sh = tsed_pkg::ACC_W'(prod) <<< {dig_q, 4'd0};
	assign acc_d   = ((dig_q == 2'd0) ? '0 : acc_q) + prod_sh;

	assign ema_step = EMA_W'(acc_q >>> tsed_pkg::ALPHA_FRAC);
	assign e1n      = e1_q + ema_step;
	assign e2n      = e2_q + ema_step;

	assign base_sum = (SUM_W'(e1_q) <<< 1) + SUM_W'(e1_q) - (SUM_W'(e2_q) <<< 1)
		- SUM_W'(e2_q) + SUM_W'(e3_q);
	always_comb begin
		priority if (base_sum > BASE_MAX) begin
			base_sat = BASE_MAX[BASE_W-1:0];
		end else if (base_sum < BASE_MIN) begin
			base_sat = BASE_MIN[BASE_W-1:0];
		end else begin
			base_sat = base_sum[BASE_W-1:0];
		end
	end

	assign r_d   = R_W'(sq) - R_W'(base_q);
	assign r_abs = r_d[R_W-1] ? R_W'(-r_d) : R_W'(r_d);

	assign nine    = {1'b0, var_q, 3'd0} + {4'd0, var_q};
	assign cap     = tsed_pkg::ACC_W'(nine) << FRACTION_BITS;
	assign clip_sh = acc_q >> FRACTION_BITS;
	always_comb begin
		if ((var_q != '0) && (tsed_pkg::ACC_W'(acc_q) > cap)) begin
			clipped = (nine[67:64] != '0) ? '1 : nine[63:0];
		end else begin
			clipped = (clip_sh[tsed_pkg::ACC_W-1:64] != '0) ? '1 : clip_sh[63:0];
		end
	end

	assign lhs_w = CMP_W'(rsq_q) << LSH;
	assign rhs_w = CMP_W'(tsed_pkg::ACC_W'(acc_q)) << RSH;
	assign gt    = lhs_w > rhs_w;

	always_comb begin
		priority if (!gt) begin
			dir = tsed_pkg::DIR_NONE;
		end else if (r_q[R_W-1]) begin
			dir = tsed_pkg::DIR_DOWN;
		end else if (r_q != '0) begin
			dir = tsed_pkg::DIR_UP;
		end else begin
			dir = tsed_pkg::DIR_NONE;
		end
	end

	assign slen_inc = slen_q + 8'd1;
	assign fire = (holdoff_q == '0) && (var_old_q != '0) && (dir != tsed_pkg::DIR_NONE)
		&& (dir == sdir_q) && (slen_inc >= persist_q);
	assign hold = fire && ev_valid_q && event_stall;
	assign ev_load = (state_q == tsed_pkg::ST_DEC) && fire && !hold && !cfg_wr_en;

	always_comb begin
		priority if (sbase_q > EMA_MAX) begin
			before_sat = EMA_MAX;
		end else if (sbase_q < EMA_MIN) begin
			before_sat = EMA_MIN;
		end else begin
			before_sat = sbase_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsed_pkg::ST_IDLE: begin
				if (accept && enable_q && seeded_q) state_d = tsed_pkg::ST_E1M;
			end
			tsed_pkg::ST_E1M:  state_d = tsed_pkg::ST_E1U;
			tsed_pkg::ST_E1U:  state_d = tsed_pkg::ST_E2M;
			tsed_pkg::ST_E2M:  state_d = tsed_pkg::ST_E2U;
			tsed_pkg::ST_E2U:  state_d = tsed_pkg::ST_E3M;
			tsed_pkg::ST_E3M:  state_d = tsed_pkg::ST_E3U;
			tsed_pkg::ST_E3U:  state_d = tsed_pkg::ST_BASE;
			tsed_pkg::ST_BASE: state_d = tsed_pkg::ST_RES;
			tsed_pkg::ST_RES:  state_d = tsed_pkg::ST_RSQ;
			tsed_pkg::ST_RSQ: begin
				if (dig_q == 2'(RSQ_DIG - 1)) state_d = tsed_pkg::ST_CLIP;
			end
			tsed_pkg::ST_CLIP: state_d = tsed_pkg::ST_VARM;
			tsed_pkg::ST_VARM: state_d = tsed_pkg::ST_VARU;
			tsed_pkg::ST_VARU: state_d = tsed_pkg::ST_KK;
			tsed_pkg::ST_KK:   state_d = tsed_pkg::ST_KKU;
			tsed_pkg::ST_KKU:  state_d = tsed_pkg::ST_THR;
			tsed_pkg::ST_THR: begin
				if (dig_q == 2'(tsed_pkg::KK_DIG - 1)) state_d = tsed_pkg::ST_DEC;
			end
			tsed_pkg::ST_DEC: begin
				if (!hold) state_d = tsed_pkg::ST_IDLE;
			end
			default: state_d = tsed_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsed_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			ema_alpha_q   <= tsed_pkg::EMA_ALPHA_RST;
			var_alpha_q   <= tsed_pkg::VAR_ALPHA_RST;
			k_q           <= tsed_pkg::K_RST;
			persist_q     <= tsed_pkg::PERSIST_RST;
			holdoff_cfg_q <= tsed_pkg::HOLDOFF_RST;
			seeded_q      <= 1'b0;
			e1_q          <= '0;
			e2_q          <= '0;
			e3_q          <= '0;
			base_q        <= '0;
			sbase_q       <= '0;
			var_q         <= '0;
			sdir_q        <= tsed_pkg::DIR_NONE;
			slen_q        <= '0;
			sidx_q        <= '0;
			holdoff_q     <= '0;
			count_q       <= '0;
			var_old_q     <= '0;
			dig_q         <= '0;
			ev_valid_q    <= 1'b0;
		end else begin
			if (ev_valid_q && !event_stall && !ev_load) ev_valid_q <= 1'b0;
			if ((state_q == tsed_pkg::ST_RSQ || state_q == tsed_pkg::ST_THR)
					&& state_d == state_q) begin
				dig_q <= dig_q + 2'd1;
			end else begin
				dig_q <= '0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					tsed_pkg::REG_ENABLE: begin
						if (cfg_data[0] && !enable_q) begin
							seeded_q  <= 1'b0;
							e1_q      <= '0;
							e2_q      <= '0;
							e3_q      <= '0;
							base_q    <= '0;
							sbase_q   <= '0;
							var_q     <= '0;
							sdir_q    <= tsed_pkg::DIR_NONE;
							slen_q    <= '0;
							sidx_q    <= '0;
							holdoff_q <= '0;
							count_q   <= '0;
						end
						enable_q <= cfg_data[0];
					end
					tsed_pkg::REG_EMA:     ema_alpha_q   <= cfg_data;
					tsed_pkg::REG_VAR:     var_alpha_q   <= cfg_data;
					tsed_pkg::REG_K:       k_q           <= cfg_data[11:0];
					tsed_pkg::REG_PERSIST: persist_q     <= cfg_data[7:0];
					tsed_pkg::REG_HOLDOFF: holdoff_cfg_q <= cfg_data;
					default: ;
				endcase
			end else begin
				unique case (state_q)
					tsed_pkg::ST_IDLE: begin
						if (accept && enable_q) begin
							count_q <= count_q + 32'd1;
							if (!seeded_q) begin
								seeded_q <= 1'b1;
								e1_q     <= EMA_W'(sample) <<< FRACTION_BITS;
								e2_q     <= EMA_W'(sample) <<< FRACTION_BITS;
								e3_q     <= EMA_W'(sample) <<< FRACTION_BITS;
								base_q   <= BASE_W'(EMA_W'(sample) <<< FRACTION_BITS);
								var_q    <= '0;
							end
						end
					end
					tsed_pkg::ST_E1U: e1_q <= e1n;
					tsed_pkg::ST_E2U: e2_q <= e2n;
					tsed_pkg::ST_E3U: e3_q <= e3_q + ema_step;
					tsed_pkg::ST_BASE: base_q <= base_sat;
					tsed_pkg::ST_CLIP: var_old_q <= var_q;
					tsed_pkg::ST_VARU: begin
						var_q <= var_q + tsed_pkg::VAR_W'(acc_q >>> tsed_pkg::ALPHA_FRAC);
					end
					tsed_pkg::ST_DEC: begin
						priority if (holdoff_q != '0) begin
							holdoff_q <= holdoff_q - 16'd1;
						end else if (var_old_q == '0) begin
							holdoff_q <= holdoff_q;
						end else if (dir == tsed_pkg::DIR_NONE) begin
							sdir_q <= tsed_pkg::DIR_NONE;
							slen_q <= '0;
						end else if (dir != sdir_q) begin
							sdir_q  <= dir;
							slen_q  <= 8'd1;
							sbase_q <= base_q;
							sidx_q  <= count_q;
						end else if (slen_inc < persist_q) begin
							slen_q <= slen_inc;
						end else if (!hold) begin
							sdir_q     <= tsed_pkg::DIR_NONE;
							slen_q     <= '0;
							holdoff_q  <= holdoff_cfg_q;
							ev_valid_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) sample_q <= sample;
		unique case (state_q)
			tsed_pkg::ST_IDLE: opa_q <= tsed_pkg::OPA_W'(sq_in) - tsed_pkg::OPA_W'(e1_q);
			tsed_pkg::ST_E1U:  opa_q <= tsed_pkg::OPA_W'(e1n) - tsed_pkg::OPA_W'(e2_q);
			tsed_pkg::ST_E2U:  opa_q <= tsed_pkg::OPA_W'(e2n) - tsed_pkg::OPA_W'(e3_q);
			tsed_pkg::ST_RES: begin
				r_q   <= r_d;
				opa_q <= $signed({{(tsed_pkg::OPA_W - R_W){1'b0}}, r_abs});
			end
			tsed_pkg::ST_CLIP: begin
				rsq_q <= tsed_pkg::ACC_W'(acc_q);
				opa_q <= $signed({2'b00, clipped}) - $signed({2'b00, var_q});
			end
			tsed_pkg::ST_VARU: opa_q <= $signed({{(tsed_pkg::OPA_W - 12){1'b0}}, k_q});
			tsed_pkg::ST_KKU: begin
				kk_q  <= acc_q[tsed_pkg::KK_W-1:0];
				opa_q <= $signed({2'b00, var_old_q});
			end
			default: ;
		endcase
		unique case (state_q)
			tsed_pkg::ST_E1M, tsed_pkg::ST_E2M, tsed_pkg::ST_E3M, tsed_pkg::ST_RSQ,
			tsed_pkg::ST_VARM, tsed_pkg::ST_KK, tsed_pkg::ST_THR: acc_q <= acc_d;
			default: ;
		endcase
		if (ev_load) begin
			ev_index_q  <= sidx_q;
			ev_before_q <= before_sat[EMA_W-1:0];
			ev_after_q  <= sample_q;
			ev_step_q   <= BASE_W'(sq) - before_sat;
			ev_down_q   <= (dir == tsed_pkg::DIR_DOWN);
		end
	end

	assign sample_stall = (state_q != tsed_pkg::ST_IDLE);
	assign event_valid  = ev_valid_q;
	assign start_index  = ev_index_q;
	assign value_before = ev_before_q;
	assign value_after  = ev_after_q;
	assign step_size    = ev_step_q;
	assign step_down    = ev_down_q;

	`TSED_ASSERT_NEXT(a_disabled_drop, accept && !enable_q && !cfg_wr_en, state_q == tsed_pkg::ST_IDLE, "disabled sample started the sequencer")
	`TSED_ASSERT_SAME(a_event_from_dec, $rose(event_valid), $past(state_q) == tsed_pkg::ST_DEC, "event raised outside the decision step")
	`TSED_ASSERT_NEXT(a_holdoff_count, state_q == tsed_pkg::ST_DEC && holdoff_q != '0, holdoff_q == $past(holdoff_q) - 16'd1, "hold-off did not count down")
	`TSED_ASSERT_NEXT(a_no_event_zero_var, state_q == tsed_pkg::ST_DEC && var_old_q == '0 && !event_valid, !event_valid, "event raised with zero variance")

endmodule
